>>> hdl/svpwm_pkg.sv
// shared types, constants and sector table for the space vector pwm block
package svpwm_pkg;

  localparam int FRAC_BITS = 24;

  localparam int AW    = 26;
  localparam int DCW   = 27;
  localparam int OFFW  = 26;
  localparam int HPW   = 16;
  localparam int DUTYW = FRAC_BITS + 1;
  localparam int CMPW  = 16;

  localparam int CFG_IDXW = 3;
  localparam int CFG_DW   = DCW;

  localparam int P1W  = AW + DCW + 1;
  localparam int SW   = P1W - FRAC_BITS;
  localparam int SQW  = 2 * AW;
  localparam int CW   = FRAC_BITS + 2;
  localparam int P2W  = CW + SW;
  localparam int TW   = P2W - FRAC_BITS + 1;
  localparam int T0W  = TW + 2;
  localparam int DW   = T0W;
  localparam int VW   = DW + 2;
  localparam int P3W  = DUTYW + HPW;

  localparam logic [DUTYW-1:0] ONE = DUTYW'(1) << FRAC_BITS;

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = n;
    r   = '0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  localparam logic signed [CW-1:0] K_SQ32 = $signed(CW'(isqrt(64'd3 << (2*FRAC_BITS - 1))));
  localparam logic signed [CW-1:0] K_SQ2H = $signed(CW'(isqrt(64'd1 << (2*FRAC_BITS - 1))));
  localparam logic signed [CW-1:0] K_SQ2  = $signed(CW'(isqrt(64'd1 << (2*FRAC_BITS + 1))));
  localparam logic signed [CW-1:0] K_ZERO = '0;

  typedef enum logic [CFG_IDXW-1:0] {
    REG_DC_SCALE    = 3'd0,
    REG_OFFSET_A    = 3'd1,
    REG_OFFSET_B    = 3'd2,
    REG_OFFSET_C    = 3'd3,
    REG_HALF_PERIOD = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEC0 = 3'd0,
    SEC1 = 3'd1,
    SEC2 = 3'd2,
    SEC3 = 3'd3,
    SEC4 = 3'd4,
    SEC5 = 3'd5
  } sector_e;

  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } phase_e;

  typedef struct packed {
    logic [DCW-1:0]         dc_scale;
    logic signed [OFFW-1:0] offset_a;
    logic signed [OFFW-1:0] offset_b;
    logic signed [OFFW-1:0] offset_c;
    logic [HPW-1:0]         half_period;
  } cfg_t;

  typedef struct packed {
    phase_e first;
    phase_e second;
    phase_e third;
  } order_t;

  typedef struct packed {
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] ya;
    logic signed [CW-1:0] xb;
    logic signed [CW-1:0] yb;
    order_t               order;
  } row_t;

  function automatic row_t sector_row(input sector_e s);
    row_t r;
    unique case (s)
      SEC0: r = '{K_SQ32, -K_SQ2H, K_ZERO, K_SQ2, '{PH_A, PH_B, PH_C}};
      SEC1: r = '{-K_SQ32, K_SQ2H, K_SQ32, K_SQ2H, '{PH_B, PH_A, PH_C}};
      SEC2: r = '{K_ZERO, K_SQ2, -K_SQ32, -K_SQ2H, '{PH_B, PH_C, PH_A}};
      SEC3: r = '{K_ZERO, -K_SQ2, -K_SQ32, K_SQ2H, '{PH_C, PH_B, PH_A}};
      SEC4: r = '{-K_SQ32, -K_SQ2H, K_SQ32, -K_SQ2H, '{PH_C, PH_A, PH_B}};
      SEC5: r = '{K_SQ32, K_SQ2H, K_ZERO, -K_SQ2, '{PH_A, PH_C, PH_B}};
      default: r = '{K_SQ32, -K_SQ2H, K_ZERO, K_SQ2, '{PH_A, PH_B, PH_C}};
    endcase
    return r;
  endfunction

endpackage

>>> hdl/svpwm_cfg_regs.sv
// configuration register file for the space vector pwm block
module svpwm_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [svpwm_pkg::CFG_IDXW-1:0]     cfg_index_i,
  input  logic [svpwm_pkg::CFG_DW-1:0]       cfg_data_i,
  output svpwm_pkg::cfg_t                    cfg_o
);

  svpwm_pkg::cfg_t cfg_q;
  svpwm_pkg::cfg_t cfg_d;
  logic            wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (svpwm_pkg::cfg_idx_e'(cfg_index_i))
        svpwm_pkg::REG_DC_SCALE:    cfg_d.dc_scale = cfg_data_i[svpwm_pkg::DCW-1:0];
        svpwm_pkg::REG_OFFSET_A:    cfg_d.offset_a = $signed(cfg_data_i[svpwm_pkg::OFFW-1:0]);
        svpwm_pkg::REG_OFFSET_B:    cfg_d.offset_b = $signed(cfg_data_i[svpwm_pkg::OFFW-1:0]);
        svpwm_pkg::REG_OFFSET_C:    cfg_d.offset_c = $signed(cfg_data_i[svpwm_pkg::OFFW-1:0]);
        svpwm_pkg::REG_HALF_PERIOD: cfg_d.half_period = cfg_data_i[svpwm_pkg::HPW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dc_scale    <= svpwm_pkg::DCW'(svpwm_pkg::ONE);
      cfg_q.offset_a    <= '0;
      cfg_q.offset_b    <= '0;
      cfg_q.offset_c    <= '0;
      cfg_q.half_period <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/svpwm_duty_and_compare.sv
// top level: space vector pwm duty and compare pipeline
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------------------
//  command  | start_i, busy_o               | alpha_i, beta_i, stop_pwm_i
//  result   | result_valid_o (one cycle)    | duty_a/b/c_o, compare_a/b/c_o,
//           |                               | forced_low_o, sector_o
//  config   | cfg_valid_i, cfg_ready_o      | cfg_index_i, cfg_data_i
//
//  eight register stages: a command transferred at a clock edge passes stages 1 to 8 in turn
//  and leaves on the result ports with result_valid_o; a new command is taken every cycle
//  the stage depth is set by the three multiplier ranks and the duty add and clamp chain
//  busy_o stays low and cfg_ready_o stays high; nothing in the pipeline ever waits
//  reset clears the stage valid bits and loads the register reset values
//  the receiver cannot stall, so results leave on their strobe cycle
module svpwm_duty_and_compare (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [svpwm_pkg::AW-1:0]        alpha_i,
  input  logic signed [svpwm_pkg::AW-1:0]        beta_i,
  input  logic                                   stop_pwm_i,
  output logic                                   result_valid_o,
  output logic [svpwm_pkg::DUTYW-1:0]            duty_a_o,
  output logic [svpwm_pkg::DUTYW-1:0]            duty_b_o,
  output logic [svpwm_pkg::DUTYW-1:0]            duty_c_o,
  output logic [svpwm_pkg::CMPW-1:0]             compare_a_o,
  output logic [svpwm_pkg::CMPW-1:0]             compare_b_o,
  output logic [svpwm_pkg::CMPW-1:0]             compare_c_o,
  output logic                                   forced_low_o,
  output logic [2:0]                             sector_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [svpwm_pkg::CFG_IDXW-1:0]         cfg_index_i,
  input  logic [svpwm_pkg::CFG_DW-1:0]           cfg_data_i
);

  localparam int FB    = svpwm_pkg::FRAC_BITS;
  localparam int NST   = 8;
  localparam int P1W   = svpwm_pkg::P1W;
  localparam int SW    = svpwm_pkg::SW;
  localparam int SQW   = svpwm_pkg::SQW;
  localparam int P2W   = svpwm_pkg::P2W;
  localparam int TW    = svpwm_pkg::TW;
  localparam int T0W   = svpwm_pkg::T0W;
  localparam int DW    = svpwm_pkg::DW;
  localparam int VW    = svpwm_pkg::VW;
  localparam int P3W   = svpwm_pkg::P3W;
  localparam int DUTYW = svpwm_pkg::DUTYW;
  localparam int CMPW  = svpwm_pkg::CMPW;

  svpwm_pkg::cfg_t cfg;
  logic            accept;

  svpwm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // stage valid bits
  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_d;

  assign vld_d = {vld_q[NST-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: scale products and squares
  logic signed [P1W-1:0] s1_pa_q, s1_pb_q;
  logic [SQW-1:0]        s1_a2_q, s1_b2_q;
  logic                  s1_a_pos_q, s1_a_neg_q, s1_b_pos_q, s1_b_zero_q, s1_stop_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pa_q     <= alpha_i * $signed({1'b0, cfg.dc_scale});
      s1_pb_q     <= beta_i * $signed({1'b0, cfg.dc_scale});
      s1_a2_q     <= alpha_i * alpha_i;
      s1_b2_q     <= beta_i * beta_i;
      s1_a_pos_q  <= (alpha_i > 0);
      s1_a_neg_q  <= alpha_i[svpwm_pkg::AW-1];
      s1_b_pos_q  <= (beta_i > 0);
      s1_b_zero_q <= (beta_i == '0);
      s1_stop_q   <= stop_pwm_i;
    end
  end

  // stage 2: sector decision and coefficient selection
  logic [SQW+1:0]      a2x3;
  logic                steep;
  svpwm_pkg::sector_e  sec_d;

  assign a2x3  = {2'b00, s1_a2_q} + {1'b0, s1_a2_q, 1'b0};
  assign steep = {2'b00, s1_b2_q} > a2x3;

  always_comb begin
    if (s1_b_pos_q) begin
      sec_d = steep ? svpwm_pkg::SEC1 : (s1_a_pos_q ? svpwm_pkg::SEC0 : svpwm_pkg::SEC2);
    end else if (s1_b_zero_q) begin
      sec_d = s1_a_neg_q ? svpwm_pkg::SEC3 : svpwm_pkg::SEC0;
    end else begin
      sec_d = steep ? svpwm_pkg::SEC4 : (s1_a_pos_q ? svpwm_pkg::SEC5 : svpwm_pkg::SEC3);
    end
  end

  logic signed [SW-1:0] s2_sa_q, s2_sb_q;
  svpwm_pkg::row_t      s2_row_q;
  svpwm_pkg::sector_e   s2_sec_q;
  logic                 s2_stop_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      s2_sa_q   <= $signed(s1_pa_q[P1W-1:FB]);
      s2_sb_q   <= $signed(s1_pb_q[P1W-1:FB]);
      s2_row_q  <= svpwm_pkg::sector_row(sec_d);
      s2_sec_q  <= sec_d;
      s2_stop_q <= s1_stop_q;
    end
  end

  // stage 3: matrix products
  logic signed [P2W-1:0] s3_p_q [4];
  svpwm_pkg::order_t     s3_ord_q;
  svpwm_pkg::sector_e    s3_sec_q;
  logic                  s3_stop_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      s3_p_q[0] <= s2_row_q.xa * s2_sa_q;
      s3_p_q[1] <= s2_row_q.ya * s2_sb_q;
      s3_p_q[2] <= s2_row_q.xb * s2_sa_q;
      s3_p_q[3] <= s2_row_q.yb * s2_sb_q;
      s3_ord_q  <= s2_row_q.order;
      s3_sec_q  <= s2_sec_q;
      s3_stop_q <= s2_stop_q;
    end
  end

  // stage 4: active times
  logic signed [TW-1:0] s4_t1_q, s4_t2_q;
  svpwm_pkg::order_t    s4_ord_q;
  svpwm_pkg::sector_e   s4_sec_q;
  logic                 s4_stop_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      s4_t1_q   <= $signed(s3_p_q[0][P2W-1:FB]) + $signed(s3_p_q[1][P2W-1:FB]);
      s4_t2_q   <= $signed(s3_p_q[2][P2W-1:FB]) + $signed(s3_p_q[3][P2W-1:FB]);
      s4_ord_q  <= s3_ord_q;
      s4_sec_q  <= s3_sec_q;
      s4_stop_q <= s3_stop_q;
    end
  end

  // stage 5: half zero time
  logic signed [T0W-1:0] t0;
  logic signed [T0W-2:0] s5_t0h_q;
  logic signed [TW-1:0]  s5_t1_q;
  logic signed [TW:0]    s5_t12_q;
  svpwm_pkg::order_t     s5_ord_q;
  svpwm_pkg::sector_e    s5_sec_q;
  logic                  s5_stop_q;

  assign t0 = $signed({1'b0, svpwm_pkg::ONE}) - s4_t1_q - s4_t2_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      s5_t0h_q  <= t0[T0W-1:1];
      s5_t1_q   <= s4_t1_q;
      s5_t12_q  <= s4_t1_q + s4_t2_q;
      s5_ord_q  <= s4_ord_q;
      s5_sec_q  <= s4_sec_q;
      s5_stop_q <= s4_stop_q;
    end
  end

  // stage 6: phase duties in sector order
  logic signed [DW-1:0] d_first, d_second, d_third;
  logic signed [DW-1:0] d_ph [3];
  logic signed [DW-1:0] s6_d_q [3];
  svpwm_pkg::sector_e   s6_sec_q;
  logic                 s6_stop_q;

  assign d_first  = DW'(s5_t0h_q);
  assign d_second = s5_t0h_q + s5_t1_q;
  assign d_third  = s5_t0h_q + s5_t12_q;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      if (s5_ord_q.first == svpwm_pkg::phase_e'(p)) begin
        d_ph[p] = d_first;
      end else if (s5_ord_q.second == svpwm_pkg::phase_e'(p)) begin
        d_ph[p] = d_second;
      end else begin
        d_ph[p] = d_third;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[4]) begin
      s6_d_q    <= d_ph;
      s6_sec_q  <= s5_sec_q;
      s6_stop_q <= s5_stop_q;
    end
  end

  // stage 7: inversion, offset and clamp
  logic signed [VW-1:0]  v_ph [3];
  logic [DUTYW-1:0]      duty_ph [3];
  logic [DUTYW-1:0]      s7_duty_q [3];
  svpwm_pkg::sector_e    s7_sec_q;
  logic                  s7_stop_q;

  assign v_ph[0] = $signed({1'b0, svpwm_pkg::ONE}) - s6_d_q[0] + cfg.offset_a;
  assign v_ph[1] = $signed({1'b0, svpwm_pkg::ONE}) - s6_d_q[1] + cfg.offset_b;
  assign v_ph[2] = $signed({1'b0, svpwm_pkg::ONE}) - s6_d_q[2] + cfg.offset_c;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      if (v_ph[p] > $signed({1'b0, svpwm_pkg::ONE})) begin
        duty_ph[p] = svpwm_pkg::ONE;
      end else if (v_ph[p] < 0) begin
        duty_ph[p] = '0;
      end else begin
        duty_ph[p] = v_ph[p][DUTYW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[5]) begin
      s7_duty_q <= duty_ph;
      s7_sec_q  <= s6_sec_q;
      s7_stop_q <= s6_stop_q;
    end
  end

  // stage 8: compare values and output register
  logic [P3W-1:0] cmp_prod [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      cmp_prod[p] = s7_duty_q[p] * cfg.half_period;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[6]) begin
      duty_a_o     <= s7_duty_q[0];
      duty_b_o     <= s7_duty_q[1];
      duty_c_o     <= s7_duty_q[2];
      compare_a_o  <= cmp_prod[0][FB +: CMPW];
      compare_b_o  <= cmp_prod[1][FB +: CMPW];
      compare_c_o  <= cmp_prod[2][FB +: CMPW];
      forced_low_o <= s7_stop_q;
      sector_o     <= s7_sec_q;
    end
  end

  assign result_valid_o = vld_q[NST-1];

  // a result appears only for a matching earlier command transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i & ~busy_o, NST))
    else $error("result without matching command transfer");

  a_stop_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> forced_low_o == $past(stop_pwm_i, NST))
    else $error("forced_low does not match stop flag of its command");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (duty_a_o <= svpwm_pkg::ONE) && (duty_b_o <= svpwm_pkg::ONE)
                       && (duty_c_o <= svpwm_pkg::ONE))
    else $error("duty above full scale");

  a_compare_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (compare_a_o <= cfg.half_period) && (compare_b_o <= cfg.half_period)
                       && (compare_c_o <= cfg.half_period))
    else $error("compare value above half period");

endmodule

>>> dv/svpwm_duty_and_compare_tb.sv
// testbench for svpwm_duty_and_compare: predicts duties, compares, forced_low and sector per command
`timescale 1ns / 1ps

module testbench;
  import svpwm_pkg::*;

  localparam longint UNITY       = longint'(1) << FRAC_BITS;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     NUM_PHASES  = 10;
  localparam int     PHASE_ITEMS = 98;
  localparam int     REPORT_MAX  = 10;

  localparam logic signed [AW-1:0] AXIS_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] AXIS_MIN = {1'b1, {(AW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][DUTYW-1:0] duty;
    logic [2:0][CMPW-1:0]  compare;
    logic                  forced_low;
    logic [2:0]            sector;
  } pwm_result_t;

  class pwm_result_book;
    pwm_result_t awaited[$];
    longint      dc_gain;
    longint      offset [3];
    longint      half_period;
    longint      root32;
    longint      root2h;
    longint      root2;
    int          error_count;

    function new();
      dc_gain     = UNITY;
      offset      = '{0, 0, 0};
      half_period = 0;
      error_count = 0;
      root32      = floor_root(longint'(3) << (2 * FRAC_BITS - 1));
      root2h      = floor_root(longint'(1) << (2 * FRAC_BITS - 1));
      root2       = floor_root(longint'(1) << (2 * FRAC_BITS + 1));
    endfunction

    function longint floor_root(longint unsigned n);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int bitpos = 31; bitpos >= 0; bitpos--) begin
        cand = r | (64'd1 << bitpos);
        if (cand * cand <= n) r = cand;
      end
      return longint'(r);
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_DC_SCALE:    dc_gain = value;
        REG_OFFSET_A:    offset[PH_A] = $signed(value[OFFW-1:0]);
        REG_OFFSET_B:    offset[PH_B] = $signed(value[OFFW-1:0]);
        REG_OFFSET_C:    offset[PH_C] = $signed(value[OFFW-1:0]);
        REG_HALF_PERIOD: half_period = value[HPW-1:0];
        default: ;
      endcase
    endfunction

    function sector_e locate_sector(longint a, longint b);
      longint  a_sq;
      longint  b_sq;
      logic    steep;
      sector_e sec;
      a_sq  = (a < 0) ? -a : a;
      b_sq  = (b < 0) ? -b : b;
      a_sq  = a_sq * a_sq * 3;
      b_sq  = b_sq * b_sq;
      steep = b_sq > a_sq;
      if (b > 0) begin
        if (steep) sec = SEC1;
        else if (a > 0) sec = SEC0;
        else sec = SEC2;
      end else if (b == 0) begin
        if (a < 0) sec = SEC3;
        else sec = SEC0;
      end else begin
        if (steep) sec = SEC4;
        else if (a > 0) sec = SEC5;
        else sec = SEC3;
      end
      return sec;
    endfunction

    function pwm_result_t compute_pwm_result(logic signed [AW-1:0] alpha,
                                             logic signed [AW-1:0] beta, logic stop);
      longint      a, b, sa, sb, xa, ya, xb, yb, t1, t2, t0, level;
      longint      d [3];
      phase_e      first, second, third;
      sector_e     sec;
      pwm_result_t res;
      a   = alpha;
      b   = beta;
      sec = locate_sector(a, b);
      case (sec)
        SEC1: begin
          xa = -root32; ya = root2h; xb = root32; yb = root2h;
          first = PH_B; second = PH_A; third = PH_C;
        end
        SEC2: begin
          xa = 0; ya = root2; xb = -root32; yb = -root2h;
          first = PH_B; second = PH_C; third = PH_A;
        end
        SEC3: begin
          xa = 0; ya = -root2; xb = -root32; yb = root2h;
          first = PH_C; second = PH_B; third = PH_A;
        end
        SEC4: begin
          xa = -root32; ya = -root2h; xb = root32; yb = -root2h;
          first = PH_C; second = PH_A; third = PH_B;
        end
        SEC5: begin
          xa = root32; ya = root2h; xb = 0; yb = -root2;
          first = PH_A; second = PH_C; third = PH_B;
        end
        default: begin
          xa = root32; ya = -root2h; xb = 0; yb = root2;
          first = PH_A; second = PH_B; third = PH_C;
        end
      endcase
      sa = (a * dc_gain) >>> FRAC_BITS;
      sb = (b * dc_gain) >>> FRAC_BITS;
      t1 = ((xa * sa) >>> FRAC_BITS) + ((ya * sb) >>> FRAC_BITS);
      t2 = ((xb * sa) >>> FRAC_BITS) + ((yb * sb) >>> FRAC_BITS);
      t0 = UNITY - t1 - t2;
      d[first]  = t0 >>> 1;
      d[second] = d[first] + t1;
      d[third]  = d[second] + t2;
      for (int i = 0; i < 3; i++) begin
        level = UNITY - d[i] + offset[i];
        if (level > UNITY) level = UNITY;
        else if (level < 0) level = 0;
        res.duty[i]    = level[DUTYW-1:0];
        res.compare[i] = CMPW'((level * half_period) >>> FRAC_BITS);
      end
      res.forced_low = stop;
      res.sector     = sec;
      return res;
    endfunction

    function void log_command(logic signed [AW-1:0] alpha, logic signed [AW-1:0] beta,
                              logic stop);
      awaited.push_back(compute_pwm_result(alpha, beta, stop));
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      error_count++;
      if (error_count <= REPORT_MAX)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(pwm_result_t seen);
      pwm_result_t want;
      string       letter [3];
      letter = '{"a", "b", "c"};
      if (awaited.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("result with no command pending: sector %0d", seen.sector);
        return;
      end
      want = awaited.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (seen.duty[i] !== want.duty[i])
          report($sformatf("duty_%s", letter[i]), want.duty[i], seen.duty[i]);
        if (seen.compare[i] !== want.compare[i])
          report($sformatf("compare_%s", letter[i]), want.compare[i], seen.compare[i]);
      end
      if (seen.forced_low !== want.forced_low)
        report("forced_low", want.forced_low, seen.forced_low);
      if (seen.sector !== want.sector)
        report("sector", want.sector, seen.sector);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic signed [AW-1:0]       alpha_i;
  logic signed [AW-1:0]       beta_i;
  logic                       stop_pwm_i;
  logic                       result_valid_o;
  logic [DUTYW-1:0]           duty_a_o;
  logic [DUTYW-1:0]           duty_b_o;
  logic [DUTYW-1:0]           duty_c_o;
  logic [CMPW-1:0]            compare_a_o;
  logic [CMPW-1:0]            compare_b_o;
  logic [CMPW-1:0]            compare_c_o;
  logic                       forced_low_o;
  logic [2:0]                 sector_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDXW-1:0]        cfg_index_i;
  logic [CFG_DW-1:0]          cfg_data_i;

  pwm_result_book tracker = new();
  int             cycle_count = 0;

  svpwm_duty_and_compare DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .alpha_i        (alpha_i),
    .beta_i         (beta_i),
    .stop_pwm_i     (stop_pwm_i),
    .result_valid_o (result_valid_o),
    .duty_a_o       (duty_a_o),
    .duty_b_o       (duty_b_o),
    .duty_c_o       (duty_c_o),
    .compare_a_o    (compare_a_o),
    .compare_b_o    (compare_b_o),
    .compare_c_o    (compare_c_o),
    .forced_low_o   (forced_low_o),
    .sector_o       (sector_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pwm_result_t seen;
    if (rst_ni && result_valid_o) begin
      seen.duty[0]    = duty_a_o;
      seen.duty[1]    = duty_b_o;
      seen.duty[2]    = duty_c_o;
      seen.compare[0] = compare_a_o;
      seen.compare[1] = compare_b_o;
      seen.compare[2] = compare_c_o;
      seen.forced_low = forced_low_o;
      seen.sector     = sector_o;
      tracker.check_result(seen);
    end
  end

  task automatic send_command(logic signed [AW-1:0] alpha, logic signed [AW-1:0] beta,
                              logic stop, int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i    <= 1'b1;
    alpha_i    <= alpha;
    beta_i     <= beta;
    stop_pwm_i <= stop;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    tracker.log_command(alpha, beta, stop);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CFG_DW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_register(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_settings(logic [CFG_DW-1:0] dc, logic [CFG_DW-1:0] off_a,
                                logic [CFG_DW-1:0] off_b, logic [CFG_DW-1:0] off_c,
                                logic [CFG_DW-1:0] hp);
    write_register(REG_DC_SCALE, dc);
    write_register(REG_OFFSET_A, off_a);
    write_register(REG_OFFSET_B, off_b);
    write_register(REG_OFFSET_C, off_c);
    write_register(REG_HALF_PERIOD, hp);
  endtask

  function automatic logic [CFG_DW-1:0] rand_offset();
    int r;
    if ($urandom_range(0, 3) == 0) return CFG_DW'($urandom);
    r = int'($urandom_range(0, 2 * UNITY)) - int'(UNITY);
    return CFG_DW'(r);
  endfunction

  function automatic logic signed [AW-1:0] rand_axis();
    int r;
    logic signed [AW-1:0] v;
    case ($urandom_range(0, 4))
      1: begin
        r = int'($urandom_range(0, 2 * UNITY)) - int'(UNITY);
        v = AW'(r);
      end
      2: begin
        r = int'($urandom_range(0, UNITY)) - int'(UNITY / 2);
        v = AW'(r);
      end
      3: begin
        case ($urandom_range(0, 4))
          0: v = AXIS_MAX;
          1: v = AXIS_MIN;
          2: v = '0;
          3: v = AW'(1);
          default: v = AW'(-1);
        endcase
      end
      default: v = AW'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    int gap;
    bit burst;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    alpha_i     <= '0;
    beta_i      <= '0;
    stop_pwm_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_DC_SCALE;
    cfg_data_i  <= '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under the reset register values
    send_command(26'sd0, 26'sd0, 1'b0, 0);
    send_command(-26'sd8388608, 26'sd0, 1'b0, 0);
    send_command(26'sd8388608, 26'sd0, 1'b0, 2);
    send_command(26'sd7264748, 26'sd4194304, 1'b0, 0);
    send_command(26'sd0, 26'sd8388608, 1'b0, 0);
    send_command(-26'sd7264748, 26'sd4194304, 1'b0, 1);
    send_command(-26'sd7264748, -26'sd4194304, 1'b0, 0);
    send_command(26'sd0, -26'sd8388608, 1'b0, 0);
    send_command(26'sd7264748, -26'sd4194304, 1'b0, 3);
    send_command(26'sd4194304, 26'sd7264747, 1'b0, 0);
    send_command(26'sd4194304, 26'sd7264748, 1'b0, 0);
    send_command(26'sd3000000, 26'sd1000000, 1'b1, 0);
    send_command(AXIS_MAX, AXIS_MAX, 1'b0, 0);
    send_command(AXIS_MIN, AXIS_MIN, 1'b1, 0);
    send_command(AXIS_MAX, AXIS_MIN, 1'b0, 1);
    send_command(AXIS_MIN, AXIS_MAX, 1'b0, 0);
    send_command(AXIS_MIN, 26'sd0, 1'b0, 0);
    send_command(26'sd0, AXIS_MIN, 1'b0, 0);
    send_command(AXIS_MAX, 26'sd0, 1'b1, 0);
    send_command(26'sd0, AXIS_MAX, 1'b0, 0);
    send_command(26'sd1, -26'sd1, 1'b0, 0);
    send_command(-26'sd1, 26'sd1, 1'b0, 0);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_settings(CFG_DW'(UNITY), 0, 0, 0, 65535);
        1: write_settings(0, CFG_DW'(-UNITY), CFG_DW'(-UNITY), CFG_DW'(-UNITY), 1);
        2: write_settings(67108864, CFG_DW'(UNITY), CFG_DW'(UNITY), CFG_DW'(UNITY), 0);
        3: write_settings(27'h7FFFFFF, 27'h1FFFFFF, 27'h2000000, 0, 65535);
        4: write_settings(CFG_DW'(UNITY), CFG_DW'(-UNITY), 0, CFG_DW'(UNITY), 40000);
        default: begin
          if ($urandom_range(0, 3) == 0)
            write_settings(CFG_DW'($urandom), rand_offset(), rand_offset(), rand_offset(),
                           CFG_DW'($urandom));
          else
            write_settings(CFG_DW'($urandom_range(0, 67108864)), rand_offset(),
                           rand_offset(), rand_offset(), CFG_DW'($urandom_range(0, 65535)));
        end
      endcase
      burst = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 16 == 0) burst = ($urandom_range(0, 2) == 0);
        gap = burst ? 0 : $urandom_range(0, 18);
        send_command(rand_axis(), rand_axis(), $urandom_range(0, 7) == 0, gap);
        if (n == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (tracker.error_count == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
